// ===== rtl/core/led_fire_effect_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// LED fire effect engine - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LED_FIRE_EFFECT_ENGINE_UNIT_MACROS_SVH
`define LED_FIRE_EFFECT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication
`define LFE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LFE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED fire effect engine - package
// Shared widths, constants, codes and types of the fire effect engine.
// ----------------------------------------------------------------------------
package lfe_pkg;

    // Default geometry
    localparam int PIXEL_COUNT_DEF = 10;
    localparam int SPARK_ZONE_DEF  = 7;

    // Field widths
    localparam int HEAT_W    = 8;
    localparam int PIX_W     = 4;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 10;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COOLING   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARK_THR = 1'd1;

    // Register reset values
    localparam logic [HEAT_W-1:0] COOLING_RESET   = 8'd55;
    localparam logic [HEAT_W-1:0] SPARK_THR_RESET = 8'd120;

    // Drift: divide by three as multiply by 683 and shift by 11
    localparam logic [MUL_W-1:0] DRIFT_RECIP = 10'd683;
    localparam int               DRIFT_SHIFT = 11;

    // Colour ramp constants
    localparam logic [MUL_W-1:0]  COLOUR_MUL   = 10'd191;
    localparam logic [15:0]       COLOUR_ROUND = 16'd127;
    localparam logic [HEAT_W-1:0] RAMP_MASK    = 8'h3F;
    localparam logic [HEAT_W-1:0] T_HIGH       = 8'h80;
    localparam logic [HEAT_W-1:0] T_MID        = 8'h40;
    localparam logic [HEAT_W-1:0] HEAT_MAX     = 8'd255;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRIFT,
        ST_SPARK_RD,
        ST_SPARK_WR,
        ST_COL_PRIME,
        ST_COLOUR
    } state_t;

    // Shared unit operations
    typedef enum logic [1:0] {
        ALU_DRIFT,
        ALU_SPARK,
        ALU_COLOUR
    } alu_op_t;

    // Shared unit results
    typedef struct packed {
        logic [HEAT_W-1:0] heat;
        logic [HEAT_W-1:0] cooled;
        logic [HEAT_W-1:0] red;
        logic [HEAT_W-1:0] green;
        logic [HEAT_W-1:0] blue;
    } alu_res_t;

endpackage

// ===== rtl/core/lfe_heat_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED fire effect engine - heat store
// One write port, one registered read port; per-entry valid bits give the
// all-zero reset and a clear of the whole store by the clr input.
// ----------------------------------------------------------------------------
module lfe_heat_mem #(
    parameter int DEPTH = lfe_pkg::PIXEL_COUNT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clr,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [lfe_pkg::HEAT_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [lfe_pkg::HEAT_W-1:0] rdata
);

    logic [lfe_pkg::HEAT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [lfe_pkg::HEAT_W-1:0] rdata_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Valid bits: cleared by reset or clear, set on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // Registered read, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lfe_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED fire effect engine - shared arithmetic unit
// Cooling subtract, drift average, spark add and colour ramp around one
// shared multiplier.
// ----------------------------------------------------------------------------
module lfe_alu (
    input  lfe_pkg::alu_op_t           op,
    input  logic [lfe_pkg::HEAT_W-1:0] heat_in,
    input  logic [lfe_pkg::HEAT_W-1:0] cool_amt,
    input  logic [lfe_pkg::HEAT_W-1:0] prev1,
    input  logic [lfe_pkg::HEAT_W-1:0] prev2,
    input  logic [lfe_pkg::HEAT_W-1:0] amount,
    output lfe_pkg::alu_res_t          res
);

    logic [lfe_pkg::HEAT_W-1:0] cooled;
    logic [lfe_pkg::MUL_W-1:0]  drift_sum;
    logic [lfe_pkg::MUL_W-1:0]  mul_a;
    logic [lfe_pkg::MUL_W-1:0]  mul_b;
    logic [lfe_pkg::PROD_W-1:0] prod;
    logic [lfe_pkg::HEAT_W:0]   spark_sum;
    logic [lfe_pkg::HEAT_W-1:0] spark_sat;
    logic [15:0]                scaled;
    logic [16:0]                div_sum;
    logic [lfe_pkg::HEAT_W-1:0] t_val;
    logic [lfe_pkg::HEAT_W-1:0] ramp;

    // Cooling, floored at zero
    assign cooled = (heat_in > cool_amt) ? (heat_in - cool_amt) : '0;

    // Drift numerator: h[k-1] + 2*h[k-2]
    assign drift_sum = {2'b00, prev1} + {1'b0, prev2, 1'b0};

    // Shared multiplier
    assign mul_a = (op == lfe_pkg::ALU_DRIFT) ? drift_sum : {2'b00, heat_in};
    assign mul_b = (op == lfe_pkg::ALU_DRIFT) ? lfe_pkg::DRIFT_RECIP : lfe_pkg::COLOUR_MUL;
    assign prod  = mul_a * mul_b;

    // Spark add, saturating
    assign spark_sum = {1'b0, heat_in} + {1'b0, amount};
    assign spark_sat = spark_sum[lfe_pkg::HEAT_W] ? lfe_pkg::HEAT_MAX
                                                   : spark_sum[lfe_pkg::HEAT_W-1:0];

    // Colour scale: t = (h*191 + 127) / 255, via (x + (x >> 8) + 1) >> 8
    assign scaled  = prod[15:0] + lfe_pkg::COLOUR_ROUND;
    assign div_sum = {1'b0, scaled} + {9'd0, scaled[15:8]} + 17'd1;
    assign t_val   = div_sum[15:8];
    assign ramp    = {t_val[5:0] & lfe_pkg::RAMP_MASK[5:0], 2'b00};

    // Result selection
    always_comb
    begin
        res.cooled = cooled;
        case (op)
            lfe_pkg::ALU_DRIFT:  res.heat = prod[lfe_pkg::DRIFT_SHIFT +: lfe_pkg::HEAT_W];
            lfe_pkg::ALU_SPARK:  res.heat = spark_sat;
            default:             res.heat = cooled;
        endcase
        if (t_val > lfe_pkg::T_HIGH)
        begin
            res.red   = lfe_pkg::HEAT_MAX;
            res.green = lfe_pkg::HEAT_MAX;
            res.blue  = ramp;
        end
        else if (t_val > lfe_pkg::T_MID)
        begin
            res.red   = lfe_pkg::HEAT_MAX;
            res.green = ramp;
            res.blue  = '0;
        end
        else
        begin
            res.red   = ramp;
            res.green = '0;
            res.blue  = '0;
        end
    end

endmodule

// ===== rtl/core/lfe_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED fire effect engine - sequencer
// Walks the heat store: cool/drift pass, optional spark, colour pass into
// the output word register.
// ----------------------------------------------------------------------------
module lfe_seq #(
    parameter int PIXEL_COUNT = lfe_pkg::PIXEL_COUNT_DEF,
    parameter int SPARK_ZONE  = lfe_pkg::SPARK_ZONE_DEF,
    parameter int AW          = $clog2(PIXEL_COUNT)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input words
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [lfe_pkg::HEAT_W-1:0] spark_roll,
    input  logic [lfe_pkg::POS_W-1:0]  spark_position,
    input  logic [lfe_pkg::HEAT_W-1:0] spark_amount,
    input  logic [lfe_pkg::HEAT_W-1:0] spark_threshold,
    // heat store
    output logic                       mem_clr,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [lfe_pkg::HEAT_W-1:0] mem_wdata,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_raddr,
    // shared unit
    output lfe_pkg::alu_op_t           alu_op,
    output logic [lfe_pkg::HEAT_W-1:0] alu_prev1,
    output logic [lfe_pkg::HEAT_W-1:0] alu_prev2,
    output logic [lfe_pkg::HEAT_W-1:0] alu_amount,
    input  lfe_pkg::alu_res_t          alu_res,
    // result words
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [lfe_pkg::PIX_W-1:0]  pixel_index,
    output logic [lfe_pkg::HEAT_W-1:0] red,
    output logic [lfe_pkg::HEAT_W-1:0] green,
    output logic [lfe_pkg::HEAT_W-1:0] blue,
    output logic                       last_pixel
);

    localparam int CW = $clog2(PIXEL_COUNT + 1);
    localparam logic [CW-1:0] CNT_END  = CW'(PIXEL_COUNT);
    localparam logic [CW-1:0] CNT_LAST = CW'(PIXEL_COUNT - 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_DRIFT_FIRST = CW'(3);

    lfe_pkg::state_t            state_reg, state_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [lfe_pkg::HEAT_W-1:0] prev1_reg, prev1_next;
    logic [lfe_pkg::HEAT_W-1:0] prev2_reg, prev2_next;
    logic                       spark_go_reg, spark_go_next;
    logic [lfe_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [lfe_pkg::HEAT_W-1:0] amount_reg, amount_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lfe_pkg::PIX_W-1:0]  out_idx_reg, out_idx_next;
    logic [lfe_pkg::HEAT_W-1:0] out_red_reg, out_red_next;
    logic [lfe_pkg::HEAT_W-1:0] out_green_reg, out_green_next;
    logic [lfe_pkg::HEAT_W-1:0] out_blue_reg, out_blue_next;
    logic                       out_last_reg, out_last_next;
    logic                       in_fire;
    logic                       out_free;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfe_pkg::ST_IDLE;
            cnt_reg       <= '0;
            spark_go_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            spark_go_reg  <= spark_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev1_reg     <= prev1_next;
        prev2_reg     <= prev2_next;
        pos_reg       <= pos_next;
        amount_reg    <= amount_next;
        out_idx_reg   <= out_idx_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
        out_blue_reg  <= out_blue_next;
        out_last_reg  <= out_last_next;
    end

    assign in_ready = (state_reg == lfe_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign alu_prev1  = prev1_reg;
    assign alu_prev2  = prev2_reg;
    assign alu_amount = amount_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        prev1_next     = prev1_reg;
        prev2_next     = prev2_reg;
        spark_go_next  = spark_go_reg;
        pos_next       = pos_reg;
        amount_next    = amount_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_last_next  = out_last_reg;
        mem_clr        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = AW'(cnt_reg - CNT_ONE);
        mem_wdata      = alu_res.cooled;
        mem_re         = 1'b0;
        mem_raddr      = AW'(cnt_reg);
        alu_op         = lfe_pkg::ALU_DRIFT;

        case (state_reg)
            lfe_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (operation)
                    begin
                        mem_clr = 1'b1;
                    end
                    else
                    begin
                        spark_go_next = (spark_roll < spark_threshold)
                                     && (32'(spark_position) < SPARK_ZONE)
                                     && (32'(spark_position) < PIXEL_COUNT);
                        pos_next      = spark_position;
                        amount_next   = spark_amount;
                        cnt_next      = '0;
                        state_next    = lfe_pkg::ST_DRIFT;
                    end
                end
            end

            // Read pixel cnt, write pixel cnt-1 from the previous read
            lfe_pkg::ST_DRIFT:
            begin
                alu_op = lfe_pkg::ALU_DRIFT;
                mem_re = (cnt_reg < CNT_END);
                if (cnt_reg != '0)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = (cnt_reg >= CNT_DRIFT_FIRST) ? alu_res.heat
                                                              : alu_res.cooled;
                    prev2_next = prev1_reg;
                    prev1_next = alu_res.cooled;
                end
                if (cnt_reg == CNT_END)
                begin
                    state_next = spark_go_reg ? lfe_pkg::ST_SPARK_RD
                                              : lfe_pkg::ST_COL_PRIME;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end

            lfe_pkg::ST_SPARK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(pos_reg);
                state_next = lfe_pkg::ST_SPARK_WR;
            end

            lfe_pkg::ST_SPARK_WR:
            begin
                alu_op     = lfe_pkg::ALU_SPARK;
                mem_we     = 1'b1;
                mem_waddr  = AW'(pos_reg);
                mem_wdata  = alu_res.heat;
                state_next = lfe_pkg::ST_COL_PRIME;
            end

            // Fetch pixel zero
            lfe_pkg::ST_COL_PRIME:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                cnt_next   = '0;
                state_next = lfe_pkg::ST_COLOUR;
            end

            // One pixel per cycle while the output register is free
            lfe_pkg::ST_COLOUR:
            begin
                alu_op = lfe_pkg::ALU_COLOUR;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = lfe_pkg::PIX_W'(cnt_reg);
                    out_red_next   = alu_res.red;
                    out_green_next = alu_res.green;
                    out_blue_next  = alu_res.blue;
                    out_last_next  = (cnt_reg == CNT_LAST);
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = lfe_pkg::ST_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(cnt_reg + CNT_ONE);
                        cnt_next  = cnt_reg + CNT_ONE;
                    end
                end
            end

            default:
            begin
                state_next = lfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = out_idx_reg;
    assign red         = out_red_reg;
    assign green       = out_green_reg;
    assign blue        = out_blue_reg;
    assign last_pixel  = out_last_reg;

endmodule

// ===== rtl/core/led_fire_effect_engine_unit.sv =====
// Frame word: cool/drift pass over the heat store, a spark read and write when the
// spark fires, a fetch of pixel zero, then one pixel word per cycle while the output
// register is free; the next word is accepted once the last pixel word is registered.
// The pixel rate is set by the single heat store read port; a clear word leaves the block idle.
// Reset: heat store reads as all zero (valid bits), cooling 55, spark threshold 120.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED fire effect engine - top level
// Per-LED heat simulation with cooling, upward drift, sparks and a
// black-red-yellow-white colour ramp, one result word per pixel.
// ----------------------------------------------------------------------------
module led_fire_effect_engine_unit #(
    parameter int PIXEL_COUNT = lfe_pkg::PIXEL_COUNT_DEF,
    parameter int SPARK_ZONE  = lfe_pkg::SPARK_ZONE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input word stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] spark_roll, [10:8] spark_position, [18:11] spark_amount
    input  logic [lfe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] operation
    input  logic                          s_axis_tuser,
    // result word stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] pixel_index, [11:4] red, [19:12] green, [27:20] blue
    output logic [lfe_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [lfe_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [lfe_pkg::HEAT_W-1:0]    cfg_wdata
);

    localparam int AW = $clog2(PIXEL_COUNT);

    logic [lfe_pkg::HEAT_W-1:0] cooling_reg;
    logic [lfe_pkg::HEAT_W-1:0] spark_thr_reg;

    logic                       mem_clr;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [lfe_pkg::HEAT_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [lfe_pkg::HEAT_W-1:0] mem_rdata;

    lfe_pkg::alu_op_t           alu_op;
    logic [lfe_pkg::HEAT_W-1:0] alu_prev1;
    logic [lfe_pkg::HEAT_W-1:0] alu_prev2;
    logic [lfe_pkg::HEAT_W-1:0] alu_amount;
    lfe_pkg::alu_res_t          alu_res;

    logic [lfe_pkg::PIX_W-1:0]  pixel_index;
    logic [lfe_pkg::HEAT_W-1:0] red;
    logic [lfe_pkg::HEAT_W-1:0] green;
    logic [lfe_pkg::HEAT_W-1:0] blue;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cooling_reg   <= lfe_pkg::COOLING_RESET;
            spark_thr_reg <= lfe_pkg::SPARK_THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lfe_pkg::CFG_COOLING:   cooling_reg   <= cfg_wdata;
                lfe_pkg::CFG_SPARK_THR: spark_thr_reg <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    lfe_heat_mem #(
        .DEPTH (PIXEL_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (mem_clr),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lfe_alu u_alu (
        .op       (alu_op),
        .heat_in  (mem_rdata),
        .cool_amt (cooling_reg),
        .prev1    (alu_prev1),
        .prev2    (alu_prev2),
        .amount   (alu_amount),
        .res      (alu_res)
    );

    lfe_seq #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .SPARK_ZONE  (SPARK_ZONE),
        .AW          (AW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .operation       (s_axis_tuser),
        .spark_roll      (s_axis_tdata[7:0]),
        .spark_position  (s_axis_tdata[10:8]),
        .spark_amount    (s_axis_tdata[18:11]),
        .spark_threshold (spark_thr_reg),
        .mem_clr         (mem_clr),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .alu_op          (alu_op),
        .alu_prev1       (alu_prev1),
        .alu_prev2       (alu_prev2),
        .alu_amount      (alu_amount),
        .alu_res         (alu_res),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .pixel_index     (pixel_index),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .last_pixel      (m_axis_tlast)
    );

    // Result word packing
    assign m_axis_tdata = {4'b0000, blue, green, red, pixel_index};

endmodule

// ===== rtl/core/lfe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED fire effect engine - port checker
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "led_fire_effect_engine_unit_macros.svh"

module lfe_checker #(
    parameter int PIXEL_COUNT = lfe_pkg::PIXEL_COUNT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lfe_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);

    localparam logic [lfe_pkg::PIX_W-1:0] LAST_IDX = lfe_pkg::PIX_W'(PIXEL_COUNT - 1);

    // A stalled result word holds
    `LFE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")

    // A frame word keeps the block busy for the next cycle
    `LFE_ASSERT_NXT(a_frame_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready, "ready right after a frame word")

    // A clear word leaves the block ready in the cycle after it
    `LFE_ASSERT_NXT(a_clear_quick, s_axis_tvalid && s_axis_tready && s_axis_tuser, s_axis_tready, "not ready after a clear word")

    // The last word of a frame carries the top pixel index
    `LFE_ASSERT_IMP(a_last_index, m_axis_tvalid && m_axis_tlast, m_axis_tdata[3:0] == LAST_IDX, "tlast on wrong pixel")

    // Padding bits stay zero
    `LFE_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:28] == 4'b0000, "nonzero padding")

endmodule

bind led_fire_effect_engine_unit lfe_checker #(.PIXEL_COUNT(PIXEL_COUNT)) u_lfe_checker (.*);
